/* rtl/assert_macros.svh */
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define CTEC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CTEC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CTEC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ctec_pkg.sv */
// types and constants of the camera trigger exposure compensation block
`default_nettype none

package ctec_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned RATE_W  = 24;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned RATE_FRAC_SHIFT = 17; // q16 scale plus the halving
	localparam int unsigned PROD_W  = TIME_W + RATE_W;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 88;
	localparam int unsigned OUT_USER_W = 2;

	typedef enum logic {
		KIND_PERIOD       = 1'b0,
		KIND_EXPOSURE_END = 1'b1
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ENABLED          = 3'd0,
		REG_COMP_ENABLE      = 3'd1,
		REG_PERIOD_TICKS     = 3'd2,
		REG_MAX_EXPOSURE_US  = 3'd3,
		REG_TICKS_PER_US_Q16 = 3'd4
	} reg_idx_t;

	localparam logic              RST_ENABLED      = 1'b0;
	localparam logic              RST_COMP_ENABLE  = 1'b1;
	localparam logic [TICK_W-1:0] RST_PERIOD_TICKS = 16'd65535;
	localparam logic [TIME_W-1:0] RST_MAX_EXPOSURE = 32'd9900;
	localparam logic [RATE_W-1:0] RST_TICKS_PER_US = 24'd3145728;

	typedef struct packed {
		logic              compare_write;
		logic [TICK_W-1:0] compare_value;
		logic [COUNT_W-1:0] image_number;
		logic [TIME_W-1:0] timestamp_us;
		logic              timestamp_valid;
		logic              trigger_pulse;
	} result_t;

endpackage

`default_nettype wire

/* rtl/camera_trigger_exposure_compensation.sv */
// camera trigger controller with mid-exposure timestamping, top level
//
// Periodic camera trigger controller. Each input transfer is one event: the
// trigger timer's period elapsed (tuser 0) or the camera's exposure-end edge
// (tuser 1), with the current microsecond time in tdata. In plain mode every
// period event fires a trigger, takes a timestamp, counts the image and
// reloads the standard period. In compensating mode the period event fires
// the trigger and re-aims the timer at mid exposure, where the next period
// event takes the timestamp. The exposure-end event measures the exposure,
// turns half of it into timer ticks (Q8.16 rate) and returns the compare
// value period minus that delay, saturating at zero; a zero or too-long
// exposure drops compensation. Every event gives exactly one result transfer.
// Rate: one event per clock cycle while the output does not stall, set by the
// exposure path state update (32x24 multiply, saturation, period subtract).
// Events pass stage s1, then s2. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`default_nettype none

module camera_trigger_exposure_compensation (
	input  wire                           clk,
	input  wire                           arst_n,
	// configuration write port
	input  wire                           cfg_we,
	input  wire  [ctec_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [ctec_pkg::CFG_W-1:0]    cfg_data,
	// event input
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire  [ctec_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [31:0] time_us
	input  wire                           s_axis_tuser,  // [0] kind
	// result output
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	// [0] trigger_pulse, [32:1] timestamp_us, [64:33] image_number,
	// [80:65] compare_value, [87:81] zero
	output logic [ctec_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] timestamp_valid, [1] compare_write
	output logic [ctec_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import ctec_pkg::*;

	`include "assert_macros.svh"

	// configuration registers
	logic              enabled_q;
	logic              comp_en_q;
	logic [TICK_W-1:0] period_q;
	logic [TIME_W-1:0] max_expo_q;
	logic [RATE_W-1:0] tpu_q;

	// controller state
	logic               compensating_q;
	logic               exposing_q;
	logic [COUNT_W-1:0] image_count_q;
	logic [TIME_W-1:0]  expo_start_q;
	logic [TICK_W-1:0]  delay_q;

	// input stage
	logic              valid_s1;
	kind_t             kind_s1;
	logic [TIME_W-1:0] time_s1;

	// result stage
	logic    valid_s2;
	result_t res_s2;

	logic advance;   // input stage moves into the result register
	logic take_in;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= RST_ENABLED;
			comp_en_q  <= RST_COMP_ENABLE;
			period_q   <= RST_PERIOD_TICKS;
			max_expo_q <= RST_MAX_EXPOSURE;
			tpu_q      <= RST_TICKS_PER_US;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLED:          enabled_q  <= cfg_data[0];
				REG_COMP_ENABLE:      comp_en_q  <= cfg_data[0];
				REG_PERIOD_TICKS:     period_q   <= cfg_data[TICK_W-1:0];
				REG_MAX_EXPOSURE_US:  max_expo_q <= cfg_data[TIME_W-1:0];
				REG_TICKS_PER_US_Q16: tpu_q      <= cfg_data[RATE_W-1:0];
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	// exposure path: length, half of it in ticks, next compare value
	logic [TIME_W-1:0] expo;
	logic [PROD_W-1:0] prod;
	logic [TICK_W-1:0] half_ticks;
	logic              expo_reject;
	logic [TICK_W-1:0] end_delay;
	logic [TICK_W-1:0] end_compare;

	assign expo        = time_s1 - expo_start_q;  // wraps modulo 2^32
	assign prod        = PROD_W'(expo) * PROD_W'(tpu_q);
	assign half_ticks  = (|prod[PROD_W-1:RATE_FRAC_SHIFT+TICK_W]) ? {TICK_W{1'b1}}
	                   : prod[RATE_FRAC_SHIFT+TICK_W-1:RATE_FRAC_SHIFT];
	assign expo_reject = (expo == '0) || (expo >= max_expo_q);
	assign end_delay   = expo_reject ? '0 : half_ticks;
	assign end_compare = (period_q > end_delay) ? (period_q - end_delay) : '0;

	// next state and result of the event in the input stage
	result_t            res_d;
	logic               compensating_d;
	logic               exposing_d;
	logic [COUNT_W-1:0] image_count_d;
	logic [TIME_W-1:0]  expo_start_d;
	logic [TICK_W-1:0]  delay_d;

	always_comb begin
		compensating_d = compensating_q;
		exposing_d     = exposing_q;
		image_count_d  = image_count_q;
		expo_start_d   = expo_start_q;
		delay_d        = delay_q;
		res_d          = '0;
		case (kind_s1)
			KIND_PERIOD: begin
				if (enabled_q) begin
					if (comp_en_q && compensating_q && exposing_q) begin
						// mid exposure: timestamp here, back to the period
						compensating_d        = 1'b0;
						res_d.timestamp_valid = 1'b1;
						res_d.timestamp_us    = time_s1;
						res_d.compare_write   = 1'b1;
						res_d.compare_value   = period_q;
					end else begin
						exposing_d          = 1'b1;
						expo_start_d        = time_s1;
						image_count_d       = image_count_q + 1'b1;
						res_d.trigger_pulse = 1'b1;
						res_d.compare_write = 1'b1;
						if (comp_en_q && compensating_q) begin
							// re-aim the timer at mid exposure
							res_d.compare_value = (delay_q != '0) ? (delay_q - 1'b1) : period_q;
						end else begin
							res_d.timestamp_valid = 1'b1;
							res_d.timestamp_us    = time_s1;
							res_d.compare_value   = period_q;
						end
					end
				end
			end
			KIND_EXPOSURE_END: begin
				if (comp_en_q) begin
					delay_d             = end_delay;
					compensating_d      = !expo_reject;
					exposing_d          = 1'b0;
					res_d.compare_write = 1'b1;
					res_d.compare_value = end_compare;
				end
			end
			default: ;
		endcase
		res_d.image_number = image_count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compensating_q <= 1'b0;
			exposing_q     <= 1'b0;
			image_count_q  <= '0;
			expo_start_q   <= '0;
			delay_q        <= '0;
		end else if (advance) begin
			compensating_q <= compensating_d;
			exposing_q     <= exposing_d;
			image_count_q  <= image_count_d;
			expo_start_q   <= expo_start_d;
			delay_q        <= delay_d;
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1 <= kind_t'(s_axis_tuser);
			time_s1 <= s_axis_tdata[TIME_W-1:0];
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_DATA_W'({res_s2.compare_value, res_s2.image_number,
	                                    res_s2.timestamp_us, res_s2.trigger_pulse});
	assign m_axis_tuser  = {res_s2.compare_write, res_s2.timestamp_valid};

	// every trigger also reloads the timer
	`CTEC_ASSERT_IMP(a_trig_writes_cmp, valid_s2 && res_s2.trigger_pulse, res_s2.compare_write, "trigger without compare write")
	// a trigger transfer counts exactly one image
	`CTEC_ASSERT_NXT(a_count_step, advance && res_d.trigger_pulse, image_count_q == $past(image_count_q) + 32'd1, "image count did not step")
	// the result carries the count left by its event
	`CTEC_ASSERT_NXT(a_count_out, advance, res_s2.image_number == image_count_q, "image number differs from state")
	// an accepted exposure end closes the exposure
	`CTEC_ASSERT_NXT(a_expo_close, advance && kind_s1 == KIND_EXPOSURE_END && comp_en_q, !exposing_q, "exposure still open after end edge")

endmodule

`default_nettype wire

/* test/testbench.sv */
// testbench for the camera trigger exposure compensation block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ctec_pkg::*;

	// ---------------------------------------------------------------------
	// timing knobs
	// ---------------------------------------------------------------------
	localparam int unsigned QUIET_LIMIT     = 5000; // cycles with no transfer at all
	localparam int unsigned RANDOM_PHASES   = 8;
	localparam int unsigned EVENTS_PER_PHASE = 135;
	localparam int unsigned MAX_REPORTS     = 10;

	// ---------------------------------------------------------------------
	// clock, reset and block ports
	// ---------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data = '0;

	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;   // [31:0] time_us
	logic                    s_axis_tuser = 1'b0; // [0] kind

	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// [0] trigger_pulse, [32:1] timestamp_us, [64:33] image_number,
	// [80:65] compare_value, [87:81] zero
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	// [0] timestamp_valid, [1] compare_write
	logic [OUT_USER_W-1:0]   m_axis_tuser;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	camera_trigger_exposure_compensation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// ---------------------------------------------------------------------
	// trigger controller model: configuration copy and camera state
	// ---------------------------------------------------------------------
	logic              cfg_enabled  = RST_ENABLED;
	logic              cfg_comp_en  = RST_COMP_ENABLE;
	logic [TICK_W-1:0] cfg_period   = RST_PERIOD_TICKS;
	logic [TIME_W-1:0] cfg_max_expo = RST_MAX_EXPOSURE;
	logic [RATE_W-1:0] cfg_rate     = RST_TICKS_PER_US;

	logic               comp_mode       = 1'b0;
	logic               exposing_now    = 1'b0;
	logic [COUNT_W-1:0] images          = '0;
	logic [TIME_W-1:0]  expo_start      = '0;
	logic [TICK_W-1:0]  half_expo_ticks = '0;

	// what the block reports for one event; advances the camera state
	function automatic result_t predict_event(kind_t k, logic [TIME_W-1:0] now);
		result_t r;
		logic [TIME_W-1:0] expo;
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] half;
		r = '0;
		if (k == KIND_PERIOD) begin
			if (cfg_enabled) begin
				if (cfg_comp_en && comp_mode) begin
					if (!exposing_now) begin
						// trigger now, re-aim the timer at mid exposure
						exposing_now = 1'b1;
						expo_start = now;
						images = images + 1'b1;
						r.trigger_pulse = 1'b1;
						r.compare_write = 1'b1;
						r.compare_value = (half_expo_ticks != '0) ?
							half_expo_ticks - 1'b1 : cfg_period;
					end else begin
						// mid exposure reached: timestamp, back to the plain period
						comp_mode = 1'b0;
						r.timestamp_valid = 1'b1;
						r.timestamp_us = now;
						r.compare_write = 1'b1;
						r.compare_value = cfg_period;
					end
				end else begin
					exposing_now = 1'b1;
					expo_start = now;
					images = images + 1'b1;
					r.trigger_pulse = 1'b1;
					r.timestamp_valid = 1'b1;
					r.timestamp_us = now;
					r.compare_write = 1'b1;
					r.compare_value = cfg_period;
				end
			end
		end else if (cfg_comp_en) begin
			// exposure length wraps with the microsecond clock
			expo = now - expo_start;
			if (expo == '0 || expo >= cfg_max_expo) begin
				half_expo_ticks = '0;
				comp_mode = 1'b0;
			end else begin
				prod = {{RATE_W{1'b0}}, expo} * {{TIME_W{1'b0}}, cfg_rate};
				half = prod >> RATE_FRAC_SHIFT;
				half_expo_ticks = (half > 'hFFFF) ? 16'hFFFF : half[TICK_W-1:0];
				comp_mode = 1'b1;
			end
			exposing_now = 1'b0;
			r.compare_write = 1'b1;
			r.compare_value = (cfg_period > half_expo_ticks) ?
				cfg_period - half_expo_ticks : '0;
		end
		r.image_number = images;
		return r;
	endfunction

	function automatic result_t mk_result(logic tp, logic tv, logic [TIME_W-1:0] ts,
		logic [COUNT_W-1:0] img, logic cw, logic [TICK_W-1:0] cv);
		result_t r;
		r.trigger_pulse = tp;
		r.timestamp_valid = tv;
		r.timestamp_us = ts;
		r.image_number = img;
		r.compare_write = cw;
		r.compare_value = cv;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// expected results and error bookkeeping
	// ---------------------------------------------------------------------
	result_t     pending_results[$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("result %0d: %s expected 0x%0h, got 0x%0h",
					results_seen, name, want, got);
		end
	endtask

	// output side: compare every result transfer with the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.trigger_pulse   = m_axis_tdata[0];
			got.timestamp_us    = m_axis_tdata[32:1];
			got.image_number    = m_axis_tdata[64:33];
			got.compare_value   = m_axis_tdata[80:65];
			got.timestamp_valid = m_axis_tuser[0];
			got.compare_write   = m_axis_tuser[1];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d: transfer with nothing expected", results_seen);
			end else begin
				want = pending_results.pop_front();
				check_field("trigger_pulse", 32'(want.trigger_pulse),
					32'(got.trigger_pulse));
				check_field("timestamp_valid", 32'(want.timestamp_valid),
					32'(got.timestamp_valid));
				check_field("timestamp_us", want.timestamp_us, got.timestamp_us);
				check_field("image_number", want.image_number, got.image_number);
				check_field("compare_write", 32'(want.compare_write),
					32'(got.compare_write));
				check_field("compare_value", 32'(want.compare_value),
					32'(got.compare_value));
			end
			results_seen++;
		end
	end

	// watchdog: nothing moving on either side for too long ends the run
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// idling of both sides
	// ---------------------------------------------------------------------
	int unsigned src_idle_pct = 0;   // chance per cycle that the sender holds back
	int unsigned sink_stall_pct = 0; // chance per cycle that the receiver stalls

	always @(negedge clk) begin
		m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
	end

	// ---------------------------------------------------------------------
	// sender and configuration tasks; all are entered at a falling edge
	// ---------------------------------------------------------------------
	// one event transfer; typed rows push their written-out result, others the model's
	task automatic send_event(kind_t k, logic [TIME_W-1:0] now, bit typed, result_t want);
		result_t model;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= now;
		s_axis_tuser  <= k;
		do
			@(posedge clk);
		while (!s_axis_tready);
		model = predict_event(k, now);
		pending_results.push_back(typed ? want : model);
		@(negedge clk);
	endtask

	// stop sending and let every outstanding result drain before going on
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_ENABLED:          cfg_enabled  = value[0];
			REG_COMP_ENABLE:      cfg_comp_en  = value[0];
			REG_PERIOD_TICKS:     cfg_period   = value[TICK_W-1:0];
			REG_MAX_EXPOSURE_US:  cfg_max_expo = value[TIME_W-1:0];
			REG_TICKS_PER_US_Q16: cfg_rate     = value[RATE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------------
	// directed script: register writes and events, walked in order
	// ---------------------------------------------------------------------
	typedef struct {
		bit                is_cfg;
		reg_idx_t          idx;
		kind_t             kind;
		logic [CFG_W-1:0]  value;   // register value, or event time
		bit                typed;
		result_t           want;
	} script_row_t;

	script_row_t script[$];

	function automatic void add_cfg(reg_idx_t idx, logic [CFG_W-1:0] value);
		script_row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.kind = KIND_PERIOD;
		r.value = value;
		r.typed = 1'b0;
		r.want = '0;
		script.push_back(r);
	endfunction

	function automatic void add_event(kind_t k, logic [TIME_W-1:0] now, bit typed, result_t want);
		script_row_t r;
		r.is_cfg = 1'b0;
		r.idx = REG_ENABLED;
		r.kind = k;
		r.value = now;
		r.typed = typed;
		r.want = want;
		script.push_back(r);
	endfunction

	function automatic void build_script();
		// disabled period event: nothing but the image count
		add_event(KIND_PERIOD, 32'd5, 1'b1,
			mk_result(1'b0, 1'b0, 32'd0, 32'd0, 1'b0, 16'd0));
		// exposure end works while disabled; zero exposure drops compensation
		add_event(KIND_EXPOSURE_END, 32'd0, 1'b1,
			mk_result(1'b0, 1'b0, 32'd0, 32'd0, 1'b1, 16'd65535));
		add_cfg(REG_ENABLED, 32'd1);
		// plain trigger with timestamp
		add_event(KIND_PERIOD, 32'd100, 1'b1,
			mk_result(1'b1, 1'b1, 32'd100, 32'd1, 1'b1, 16'd65535));
		// 5000 us at 48 ticks/us saturates the delay, the compare saturates at zero
		add_event(KIND_EXPOSURE_END, 32'd5100, 1'b1,
			mk_result(1'b0, 1'b0, 32'd0, 32'd1, 1'b1, 16'd0));
		// compensating trigger re-aims at delay - 1
		add_event(KIND_PERIOD, 32'd20000, 1'b1,
			mk_result(1'b1, 1'b0, 32'd0, 32'd2, 1'b1, 16'd65534));
		// mid-exposure timestamp
		add_event(KIND_PERIOD, 32'd20500, 1'b1,
			mk_result(1'b0, 1'b1, 32'd20500, 32'd2, 1'b1, 16'd65535));
		add_cfg(REG_PERIOD_TICKS, 32'd1000);
		add_event(KIND_EXPOSURE_END, 32'd20010, 1'b0, '0);
		add_event(KIND_PERIOD, 32'd30000, 1'b0, '0);
		add_event(KIND_PERIOD, 32'd30100, 1'b0, '0);
		// exposure exactly at the limit is rejected, one below is accepted
		add_cfg(REG_MAX_EXPOSURE_US, 32'd500);
		add_event(KIND_EXPOSURE_END, 32'd30500, 1'b0, '0);
		add_event(KIND_PERIOD, 32'd40000, 1'b0, '0);
		add_event(KIND_EXPOSURE_END, 32'd40499, 1'b0, '0);
		// slow rate: nonzero exposure but zero delay; time wraps across the exposure
		add_cfg(REG_TICKS_PER_US_Q16, 32'd1);
		add_event(KIND_PERIOD, 32'hFFFF_FFF0, 1'b0, '0);
		add_event(KIND_EXPOSURE_END, 32'h0000_0010, 1'b0, '0);
		add_event(KIND_PERIOD, 32'h0000_0100, 1'b0, '0);
		add_event(KIND_PERIOD, 32'h0000_0200, 1'b0, '0);
		// compensation switched off: exposure end ignored, period events plain
		add_cfg(REG_COMP_ENABLE, 32'd0);
		add_event(KIND_EXPOSURE_END, 32'h0000_0300, 1'b0, '0);
		add_event(KIND_PERIOD, 32'hFFFF_FFFF, 1'b0, '0);
		// all extremes: widest limit, fastest rate, zero period
		add_cfg(REG_COMP_ENABLE, 32'd1);
		add_cfg(REG_MAX_EXPOSURE_US, 32'hFFFF_FFFF);
		add_cfg(REG_TICKS_PER_US_Q16, 32'h00FF_FFFF);
		add_cfg(REG_PERIOD_TICKS, 32'd0);
		add_event(KIND_EXPOSURE_END, 32'hFFFF_FFFD, 1'b0, '0);
		add_event(KIND_PERIOD, 32'h0000_0000, 1'b0, '0);
		add_event(KIND_PERIOD, 32'h0000_0001, 1'b0, '0);
		add_cfg(REG_PERIOD_TICKS, 32'd65535);
		add_event(KIND_PERIOD, 32'hAAAA_5555, 1'b0, '0);
		add_cfg(REG_ENABLED, 32'd0);
		add_event(KIND_PERIOD, 32'h1234_5678, 1'b0, '0);
		add_event(KIND_EXPOSURE_END, 32'h5555_AAAA, 1'b0, '0);
	endfunction

	// exposure length for a well-formed sequence, biased to the limit's edges
	function automatic logic [TIME_W-1:0] pick_exposure();
		logic [TIME_W-1:0] cap;
		cap = (cfg_max_expo > 1 && cfg_max_expo <= 20000) ? cfg_max_expo - 1 : 32'd20000;
		case ($urandom_range(9))
			0: return '0;
			1: return cfg_max_expo;
			2: return cfg_max_expo - 1'b1;
			3: return $urandom;
			default: return $urandom_range(1, cap);
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------
	int unsigned src_pct_of_mode[4]  = '{0, 67, 0, 38};
	int unsigned sink_pct_of_mode[4] = '{0, 0, 67, 38};

	initial begin
		logic [TIME_W-1:0] clock_us;
		logic [TIME_W-1:0] trig_us;
		logic [CFG_W-1:0]  v;
		int unsigned       step;
		kind_t             k;

		build_script();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, no idling
		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				wait_idle();
				write_reg(script[i].idx, script[i].value);
			end else begin
				send_event(script[i].kind, script[i].value, script[i].typed, script[i].want);
			end
		end

		// random part: each phase has its own settings and idling mode
		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			src_idle_pct   = src_pct_of_mode[phase % 4];
			sink_stall_pct = sink_pct_of_mode[phase % 4];

			write_reg(REG_ENABLED, ($urandom_range(9) != 0) ? 32'd1 : 32'd0);
			write_reg(REG_COMP_ENABLE, ($urandom_range(4) != 0) ? 32'd1 : 32'd0);
			case ($urandom_range(3))
				0: v = 32'd0;
				1: v = 32'd65535;
				2: v = $urandom_range(0, 65535);
				default: v = $urandom_range(100, 3000);
			endcase
			write_reg(REG_PERIOD_TICKS, v);
			case ($urandom_range(4))
				0: v = 32'd0;
				1: v = 32'hFFFF_FFFF;
				2: v = RST_MAX_EXPOSURE;
				3: v = $urandom;
				default: v = $urandom_range(1, 50000);
			endcase
			write_reg(REG_MAX_EXPOSURE_US, v);
			case ($urandom_range(4))
				0: v = 32'd0;
				1: v = 32'h00FF_FFFF;
				2: v = CFG_W'(RST_TICKS_PER_US);
				3: v = $urandom_range(1, 32'h0002_0000);
				default: v = $urandom_range(0, 32'h00FF_FFFF);
			endcase
			write_reg(REG_TICKS_PER_US_Q16, v);

			// some phases start just below the wrap of the microsecond clock
			clock_us = ($urandom_range(3) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535)
				: $urandom;
			trig_us = clock_us;
			step = 0;
			for (int unsigned n = 0; n < EVENTS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 12) begin
					// noise: any kind at any time, breaks the sequence
					k = $urandom_range(1) ? KIND_EXPOSURE_END : KIND_PERIOD;
					send_event(k, $urandom, 1'b0, '0);
				end else begin
					// well-formed cycle: trigger, exposure end, mid-exposure period
					case (step)
						0: begin
							clock_us = clock_us + $urandom_range(0, 30000);
							trig_us = clock_us;
							send_event(KIND_PERIOD, clock_us, 1'b0, '0);
						end
						1: begin
							clock_us = trig_us + pick_exposure();
							send_event(KIND_EXPOSURE_END, clock_us, 1'b0, '0);
						end
						default: begin
							clock_us = clock_us + $urandom_range(0, 30000);
							send_event(KIND_PERIOD, clock_us, 1'b0, '0);
						end
					endcase
					step = (step == 2) ? 0 : step + 1;
				end
			end
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (pending_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
